### rtl/dfir_pkg.sv
// ---------------------------------------------------------------------------
// dfir_pkg
// Shared types, constants and the coefficient lookup for the decimating FIR.
// ---------------------------------------------------------------------------
package dfir_pkg;

  // sample and result widths
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned OUT_W    = 8;

  // coefficient format
  localparam int unsigned COEF_W     = 14;
  localparam int unsigned COEF_COUNT = 9;

  // default configuration
  localparam int unsigned TAPS_DEF       = 9;
  localparam int unsigned DECIMATION_DEF = 3;
  localparam int unsigned SHIFT_DEF      = 14;

  // controller to datapath commands
  typedef struct packed {
    logic shift_in;   // push accepted sample into the delay line
    logic mac_clear;  // clear accumulator and tap counter
    logic mac_step;   // one multiply-accumulate and rotate
    logic out_load;   // load scaled sum into the output register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last_tap;   // current mac step is the final tap
  } sts_t;

  // symmetric low-pass coefficients, zero beyond the stored set
  function automatic logic signed [COEF_W-1:0] coef_at(input int unsigned j);
    logic signed [COEF_W-1:0] c;
    case (j)
      0:       c = -14'sd95;
      1:       c = 14'sd0;
      2:       c = 14'sd1286;
      3:       c = 14'sd4121;
      4:       c = 14'sd5759;
      5:       c = 14'sd4121;
      6:       c = 14'sd1286;
      7:       c = 14'sd0;
      8:       c = -14'sd95;
      default: c = 14'sd0;
    endcase
    return c;
  endfunction

endpackage

### rtl/decimating_fir_filter_top.sv
// ---------------------------------------------------------------------------
// decimating_fir_filter_top
// Decimating FIR filter with a single shared multiply-accumulate unit.
// ---------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_ channel, one signed byte per transfer, and are
//   pushed into a TAPS-deep delay line. Every DECIMATION-th sample yields one
//   signed byte on the m_ channel: the dot product of the line with the fixed
//   coefficients, arithmetic shifted right by SHIFT, low 8 bits kept (wraps).
//   cfg_we/cfg_wdata write round_enable; when set, the highest dropped bit is
//   added before the low 8 bits are taken.
// Sequence:
//   A sample that yields no result leaves s_tready high for the next one. For
//   a decimating sample the MAC unit walks the taps one per cycle by rotating
//   the delay line, then the scaled sum is loaded into the output register
//   once that is free; s_tready stays low until the load.
// Reset and stall:
//   rst clears the delay line, the phase counter and round_enable. A result
//   holds in the output register while m_tready is low; further samples are
//   still taken up to the next decimating one, whose sum then waits in the
//   accumulator and holds s_tready low until the output register frees up.
// ---------------------------------------------------------------------------
module decimating_fir_filter_top #(
  parameter int unsigned TAPS       = dfir_pkg::TAPS_DEF,
  parameter int unsigned DECIMATION = dfir_pkg::DECIMATION_DEF,
  parameter int unsigned SHIFT      = dfir_pkg::SHIFT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_wdata,   // round_enable
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic signed [dfir_pkg::SAMPLE_W-1:0] s_tdata,     // [7:0] sample
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic signed [dfir_pkg::OUT_W-1:0]    m_tdata      // [7:0] filtered
);

  dfir_pkg::cmd_t cmd;
  dfir_pkg::sts_t sts;

  // sequencer
  dfir_ctrl #(
    .DECIMATION(DECIMATION)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd),
    .sts      (sts)
  );

  // delay line and mac
  dfir_datapath #(
    .TAPS  (TAPS),
    .SHIFT (SHIFT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sample    (s_tdata),
    .filtered  (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### rtl/dfir_ctrl.sv
// ---------------------------------------------------------------------------
// dfir_ctrl
// Phase counter and sequencer for the shared multiply-accumulate unit.
// ---------------------------------------------------------------------------
module dfir_ctrl #(
  parameter int unsigned DECIMATION = dfir_pkg::DECIMATION_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic              m_tready,
  output logic              m_tvalid,
  output dfir_pkg::cmd_t    cmd,
  input  dfir_pkg::sts_t    sts
);

  localparam int unsigned PH_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(DECIMATION - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAC  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]      state;
  logic [1:0]      state_next;
  logic [PH_W-1:0] phase;
  logic            s_fire;
  logic            last_phase;
  logic            out_free;

  // handshake terms
  assign s_tready   = (state == ST_IDLE);
  assign s_fire     = s_tvalid && s_tready;
  assign last_phase = (phase == PH_LAST);
  assign out_free   = !m_tvalid || m_tready;

  // commands to the datapath
  assign cmd.shift_in  = s_fire;
  assign cmd.mac_clear = s_fire && last_phase;
  assign cmd.mac_step  = (state == ST_MAC);
  assign cmd.out_load  = (state == ST_OUT) && out_free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_fire && last_phase) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        if (sts.last_tap) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state, phase counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (s_fire) begin
        phase <= last_phase ? '0 : phase + 1'b1;
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // phase counter stays within the decimation factor
  assert property (@(posedge clk) disable iff (rst) phase <= PH_LAST)
    else $error("phase counter out of range");

  // a decimating transfer starts the mac sequence
  assert property (@(posedge clk) disable iff (rst)
    (s_fire && last_phase) |=> (state == ST_MAC))
    else $error("mac sequence did not start");

  // other transfers leave the block ready for the next sample
  assert property (@(posedge clk) disable iff (rst)
    (s_fire && !last_phase) |=> (state == ST_IDLE))
    else $error("non-decimating transfer left idle");

  // a load always presents a result in the next cycle
  assert property (@(posedge clk) disable iff (rst) cmd.out_load |=> m_tvalid)
    else $error("loaded result not valid");

endmodule

### rtl/dfir_datapath.sv
// ---------------------------------------------------------------------------
// dfir_datapath
// Delay line, shared multiply-accumulate unit and scaled output register.
// ---------------------------------------------------------------------------
module dfir_datapath #(
  parameter int unsigned TAPS  = dfir_pkg::TAPS_DEF,
  parameter int unsigned SHIFT = dfir_pkg::SHIFT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_wdata,
  input  logic signed [dfir_pkg::SAMPLE_W-1:0] sample,
  output logic signed [dfir_pkg::OUT_W-1:0]    filtered,
  input  dfir_pkg::cmd_t                      cmd,
  output dfir_pkg::sts_t                      sts
);

  localparam int unsigned TAP_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int unsigned PROD_W = dfir_pkg::SAMPLE_W + dfir_pkg::COEF_W;
  localparam int unsigned SUM_W  = PROD_W + TAP_W + 1;
  localparam int unsigned ACC_W  = (SUM_W > SHIFT + dfir_pkg::OUT_W + 1) ?
                                   SUM_W : SHIFT + dfir_pkg::OUT_W + 1;

  logic signed [dfir_pkg::SAMPLE_W-1:0] delay [TAPS];
  logic [TAP_W-1:0]                     tap_idx;
  logic signed [ACC_W-1:0]              acc;
  logic                                 round_en;
  logic signed [dfir_pkg::COEF_W-1:0]   coef;
  logic signed [PROD_W-1:0]             prod;
  logic [dfir_pkg::OUT_W-1:0]           scaled;

  // coefficient for the tap at the head of the rotating line
  assign coef = dfir_pkg::coef_at(32'(tap_idx));
  assign prod = delay[0] * coef;
  assign sts.last_tap = (tap_idx == TAP_W'(TAPS - 1));

  // bits SHIFT up of the sum, plus the highest dropped bit when rounding
  assign scaled = acc[SHIFT +: dfir_pkg::OUT_W] +
                  {{(dfir_pkg::OUT_W-1){1'b0}}, round_en & acc[SHIFT-1]};

  // rounding control register
  always_ff @(posedge clk) begin
    if (rst) begin
      round_en <= 1'b0;
    end else if (cfg_we) begin
      round_en <= cfg_wdata;
    end
  end

  // delay line: shift on transfer, rotate one place per mac step
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAPS; i++) begin
        delay[i] <= '0;
      end
    end else if (cmd.shift_in) begin
      delay[0] <= sample;
      for (int i = 1; i < TAPS; i++) begin
        delay[i] <= delay[i-1];
      end
    end else if (cmd.mac_step) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        delay[i] <= delay[i+1];
      end
      delay[TAPS-1] <= delay[0];
    end
  end

  // accumulator and tap counter
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_idx <= '0;
    end else if (cmd.mac_clear) begin
      tap_idx <= '0;
    end else if (cmd.mac_step && !sts.last_tap) begin
      tap_idx <= tap_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_clear) begin
      acc <= '0;
    end else if (cmd.mac_step) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // output data register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      filtered <= scaled;
    end
  end

  // the counter is parked at zero whenever a new sum starts
  assert property (@(posedge clk) disable iff (rst) cmd.mac_clear |=> (tap_idx == '0))
    else $error("tap counter not cleared");

  // a clear and a step never come together
  assert property (@(posedge clk) disable iff (rst) !(cmd.mac_clear && cmd.mac_step))
    else $error("clear during mac step");

  // the line only moves for one reason at a time
  assert property (@(posedge clk) disable iff (rst) !(cmd.shift_in && cmd.mac_step))
    else $error("shift during mac step");

endmodule

### tb/sv/tb_decimating_fir_filter_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_decimating_fir_filter_top
// Self-checking bench for the decimating FIR filter.
// ---------------------------------------------------------------------------
// Samples go in as stream transfers in random bursts. A scoreboard follows
// the delay line, the decimation phase and round_enable, and works out each
// filtered byte. Each result transfer is compared with the oldest waiting
// prediction. Directed windows hit the sample extremes, output wrap and the
// rounding carry from 127 to -128. Random phases then run with rounding on
// and off, with and without sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module tb_decimating_fir_filter_top;

  localparam int unsigned SAMPLE_W   = dfir_pkg::SAMPLE_W;
  localparam int unsigned OUT_W      = dfir_pkg::OUT_W;
  localparam int unsigned COEF_COUNT = dfir_pkg::COEF_COUNT;

  localparam int NUM_TAPS     = dfir_pkg::TAPS_DEF;
  localparam int DEC_FACTOR   = dfir_pkg::DECIMATION_DEF;
  localparam int SCALE_SHIFT  = dfir_pkg::SHIFT_DEF;
  localparam int SETTLE_CYC   = 2 * (dfir_pkg::TAPS_DEF + 2);
  localparam int LIMIT_CYCLES = 200000;

  // low-pass tap weights, oldest and newest ends carry the small negative lobes
  localparam int LP_WEIGHTS [COEF_COUNT] = '{-95, 0, 1286, 4121, 5759, 4121, 1286, 0, -95};

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic                       cfg_wdata = 1'b0;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic signed [SAMPLE_W-1:0] s_tdata = '0;    // [7:0] sample
  logic                       m_tvalid;
  logic                       m_tready = 1'b1;
  logic signed [OUT_W-1:0]    m_tdata;         // [7:0] filtered

  // scoreboard state
  logic signed [SAMPLE_W-1:0] fir_line [NUM_TAPS];
  int                         dec_phase;
  logic                       round_mode;
  logic signed [OUT_W-1:0]    filtered_q [$];

  int errors       = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int cycles       = 0;

  // receiver stall control
  int rx_stall_pct = 0;
  int rx_max_stall = 1;
  int rx_run       = 0;

  decimating_fir_filter_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("[decimating_fir_filter_top] ERROR");
      $finish;
    end
  end

  // receiver: random runs of ready and stall
  always @(posedge clk) begin
    if (rx_run == 0) begin
      if ($urandom_range(0, 99) < rx_stall_pct) begin
        m_tready <= 1'b0;
        rx_run   <= $urandom_range(1, rx_max_stall);
      end else begin
        m_tready <= 1'b1;
        rx_run   <= $urandom_range(1, 40);
      end
    end else begin
      rx_run <= rx_run - 1;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (filtered_q.size() == 0) begin
        $error("filtered: unexpected transfer, actual %0d", m_tdata);
        errors++;
      end else begin
        if (m_tdata !== filtered_q[0]) begin
          $error("filtered mismatch: expected %0d, actual %0d", filtered_q[0], m_tdata);
          errors++;
        end
        void'(filtered_q.pop_front());
      end
    end
  end

  // shift one accepted sample in and predict the decimated output
  function automatic void push_sample(input logic signed [SAMPLE_W-1:0] smp);
    longint      acc;
    longint      scaled;
    logic [63:0] scaled_bits;
    acc = 0;
    for (int k = NUM_TAPS - 1; k > 0; k--) fir_line[k] = fir_line[k-1];
    fir_line[0] = smp;
    if (dec_phase + 1 < DEC_FACTOR) begin
      dec_phase++;
      return;
    end
    dec_phase = 0;
    for (int k = 0; k < NUM_TAPS; k++) begin
      if (k < COEF_COUNT) acc += longint'(fir_line[k]) * longint'(LP_WEIGHTS[k]);
    end
    scaled = acc >>> SCALE_SHIFT;
    if (round_mode) scaled = scaled + longint'(acc[SCALE_SHIFT-1]);
    scaled_bits = scaled;
    filtered_q.push_back(scaled_bits[OUT_W-1:0]);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input bit loud);
    int mag;
    mag = $urandom_range(96, 127);
    case ($urandom_range(0, 7))
      0: return 8'sd127;
      1: return -8'sd128;
      default: begin
        if (loud) return SAMPLE_W'(($urandom_range(0, 3) == 0) ? -mag : mag);
        return SAMPLE_W'($urandom_range(0, 255));
      end
    endcase
  endfunction

  // one sample transfer; valid stays up for the caller to reuse
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    push_sample(smp);
    samples_sent++;
  endtask

  task automatic idle_cycles(input int n);
    s_tvalid <= 1'b0;
    s_tdata  <= SAMPLE_W'($urandom_range(0, 255));
    repeat (n) @(posedge clk);
  endtask

  // hold the sender until every predicted result has come out
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (filtered_q.size() != 0);
  endtask

  // round_enable write, only with the filter idle
  task automatic write_round(input logic val);
    drain_results();
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    round_mode = val;
    cfg_we    <= 1'b0;
  endtask

  task automatic send_window(input logic signed [SAMPLE_W-1:0] win [NUM_TAPS]);
    for (int k = 0; k < NUM_TAPS; k++) send_sample(win[k]);
  endtask

  // full-scale windows: wrap past +127, then all -128
  task automatic test_wrap_extremes();
    logic signed [SAMPLE_W-1:0] win [NUM_TAPS];
    write_round(1'b0);
    win = '{-8'sd128, 8'sd0, 8'sd127, 8'sd127, 8'sd127, 8'sd127, 8'sd127, 8'sd0, -8'sd128};
    send_window(win);
    win = '{default: -8'sd128};
    send_window(win);
  endtask

  // scaled sum just under 128 with the dropped bit set: rounds to -128
  task automatic test_round_overflow();
    logic signed [SAMPLE_W-1:0] win [NUM_TAPS];
    write_round(1'b1);
    win = '{8'sd64, 8'sd0, 8'sd127, 8'sd127, 8'sd127, 8'sd127, 8'sd127, 8'sd0, 8'sd64};
    send_window(win);
  endtask

  // random bursts with optional gaps, stalls and the odd full drain
  task automatic test_random_stream(input int n, input logic rnd, input int max_gap,
                                    input int stall_pct, input int max_stall);
    int  sent;
    int  burst;
    int  gap;
    bit  loud;
    sent = 0;
    write_round(rnd);
    rx_stall_pct = stall_pct;
    rx_max_stall = max_stall;
    while (sent < n) begin
      burst = $urandom_range(1, 24);
      loud  = ($urandom_range(0, 2) == 0);
      for (int b = 0; b < burst && sent < n; b++) begin
        send_sample(pick_sample(loud));
        sent++;
      end
      gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
      if (gap != 0) idle_cycles(gap);
      if ($urandom_range(0, 39) == 0) drain_results();
    end
  endtask

  initial begin
    for (int k = 0; k < NUM_TAPS; k++) fir_line[k] = '0;
    dec_phase  = 0;
    round_mode = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_wrap_extremes();
    test_round_overflow();
    test_random_stream(150, 1'b1, 0, 0, 1);
    test_random_stream(150, 1'b0, 6, 30, 12);
    test_random_stream(150, 1'b1, 3, 60, 25);

    drain_results();
    repeat (SETTLE_CYC) @(posedge clk);

    $display("covered %0d sample transfers and %0d filtered results,", samples_sent,
             results_seen);
    $display("rounding on and off, full-scale wrap, sender gaps and receiver stalls");
    if (errors == 0) begin
      $display("[decimating_fir_filter_top] OK");
    end else begin
      $display("[decimating_fir_filter_top] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/dfir_pkg.sv
rtl/dfir_ctrl.sv
rtl/dfir_datapath.sv
rtl/decimating_fir_filter_top.sv
tb/sv/tb_decimating_fir_filter_top.sv
